### src/osg_pkg.sv
package osg_pkg;

  localparam int unsigned MAX_LAYERS_DEFAULT = 4;
  localparam int unsigned COORD_W            = 32;
  localparam int unsigned LAYER_W            = 3;
  localparam int unsigned SLOT_W             = 3;
  localparam int unsigned CHILDREN           = 8;
  localparam int unsigned CFG_INDEX_W        = 3;
  localparam int unsigned CFG_DATA_W         = 32;

  // Configuration register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LAYER_COUNT,
    REG_ROOT_MIN_X,
    REG_ROOT_MAX_X,
    REG_ROOT_MIN_Y,
    REG_ROOT_MAX_Y,
    REG_ROOT_MIN_Z,
    REG_ROOT_MAX_Z
  } osg_reg_t;

  typedef logic signed [COORD_W-1:0] osg_coord_t;

  // One axis of a box: max in the upper half, min in the lower half
  typedef struct packed {
    osg_coord_t hi;
    osg_coord_t lo;
  } osg_span_t;

  typedef struct packed {
    osg_span_t x;
    osg_span_t y;
    osg_span_t z;
  } osg_box_t;

  // Per-transaction decision from the traversal sequencer
  typedef struct packed {
    logic              emit;
    logic              is_root;
    logic              has_children;
    logic              last_node;
    logic [SLOT_W-1:0] slot;
  } osg_step_t;

  // Node count of a complete octree with the given levels below the root
  function automatic int unsigned tree_nodes(input int unsigned levels);
    int unsigned total;
    int unsigned width;
    total = 0;
    width = 1;
    for (int unsigned d = 0; d <= levels; d++) begin
      total = total + width;
      width = width * CHILDREN;
    end
    return total;
  endfunction

  // floor((a + b) / 2) taken at one extra bit
  function automatic osg_coord_t midpoint(input osg_coord_t a, input osg_coord_t b);
    logic signed [COORD_W:0] sum;
    sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return sum[COORD_W:1];
  endfunction

  // Pick the low or high half of a span
  function automatic osg_span_t split(input osg_span_t s, input logic upper);
    osg_span_t  r;
    osg_coord_t m;
    m = midpoint(s.lo, s.hi);
    if (upper) begin
      r.lo = m;
      r.hi = s.hi;
    end else begin
      r.lo = s.lo;
      r.hi = m;
    end
    return r;
  endfunction

endpackage

### src/osg_sequencer.sv
module osg_sequencer #(
  parameter int unsigned MAX_LAYERS = osg_pkg::MAX_LAYERS_DEFAULT,
  parameter int unsigned NODE_W     = 3 * MAX_LAYERS + 1,
  parameter int unsigned PARENT_W   = 3 * MAX_LAYERS - 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         restart,
  input  logic [osg_pkg::LAYER_W-1:0]  layer_count,
  output osg_pkg::osg_step_t           step,
  output logic [NODE_W-1:0]            node,
  output logic [PARENT_W-1:0]          parent
);
  import osg_pkg::*;

  logic [NODE_W-1:0]   next_node;
  logic [PARENT_W-1:0] current_parent;
  logic [SLOT_W-1:0]   child_slot;
  logic                finished;

  logic [NODE_W-1:0]   total_tab    [0:(1 << LAYER_W) - 1];
  logic [NODE_W-1:0]   internal_tab [0:(1 << LAYER_W) - 1];

  logic [NODE_W-1:0]   total;
  logic [NODE_W-1:0]   internal;
  logic [NODE_W-1:0]   node_inc;
  logic [SLOT_W-1:0]   eff_slot;
  logic                eff_finished;

  // Tree size per layer setting, oversized settings clamp to the maximum depth
  for (genvar g = 0; g < (1 << LAYER_W); g++) begin : g_tab
    localparam int unsigned LV = (g > MAX_LAYERS) ? MAX_LAYERS : g;
    assign total_tab[g]    = NODE_W'(tree_nodes(LV));
    // interior nodes: everything except the deepest level
    assign internal_tab[g] = NODE_W'(tree_nodes(LV) - (1 << (3 * LV)));
  end

  assign total    = total_tab[layer_count];
  assign internal = internal_tab[layer_count];

  // Apply restart before deciding on this transaction
  always_comb begin
    node         = restart ? '0 : next_node;
    parent       = restart ? '0 : current_parent;
    eff_slot     = restart ? '0 : child_slot;
    eff_finished = restart ? 1'b0 : finished;
    node_inc     = node + NODE_W'(1);

    step.emit         = !eff_finished && (node < total);
    step.is_root      = (node == '0);
    step.has_children = (node < internal);
    step.last_node    = (node_inc == total);
    step.slot         = eff_slot;
  end

  // Advance the breadth-first position
  always_ff @(posedge clk) begin
    if (rst) begin
      next_node      <= '0;
      current_parent <= '0;
      child_slot     <= '0;
      finished       <= 1'b0;
    end else if (accept) begin
      if (step.emit) begin
        next_node <= node_inc;
        finished  <= step.last_node;
        if (step.is_root) begin
          current_parent <= '0;
          child_slot     <= '0;
        end else if (eff_slot == SLOT_W'(CHILDREN - 1)) begin
          current_parent <= parent + PARENT_W'(1);
          child_slot     <= '0;
        end else begin
          child_slot <= eff_slot + SLOT_W'(1);
        end
      end else begin
        finished <= 1'b1;
      end
    end
  end

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && step.emit) |=> (next_node == $past(node) + NODE_W'(1)))
    else $error("node position did not advance by one");

  a_parent: assert property (@(posedge clk) disable iff (rst)
    (step.emit && !step.is_root) |->
      (NODE_W'(parent) == ((node - NODE_W'(1)) >> 3)))
    else $error("parent index out of step with node index");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    (accept && step.emit && step.last_node) |=> finished)
    else $error("tree not marked finished after last node");

endmodule

### src/osg_box_store.sv
module osg_box_store #(
  parameter int unsigned DEPTH = 585,
  parameter int unsigned AW    = 10
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  osg_pkg::osg_span_t wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output osg_pkg::osg_span_t rdata
);
  import osg_pkg::*;

  osg_span_t mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/osg_emit_stage.sv
module osg_emit_stage #(
  parameter int unsigned NODE_W   = 13,
  parameter int unsigned PARENT_W = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  osg_pkg::osg_step_t          step,
  input  logic [NODE_W-1:0]           node,
  input  logic [PARENT_W-1:0]         parent,
  input  osg_pkg::osg_box_t           root_box,
  input  osg_pkg::osg_box_t           parent_box,
  output logic                        busy,
  output logic                        wr_en,
  output logic [NODE_W-1:0]           wr_node,
  output osg_pkg::osg_box_t           wr_box,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [NODE_W-1:0]           node_index,
  output logic signed [PARENT_W:0]    parent_index,
  output osg_pkg::osg_coord_t         box_min_x,
  output osg_pkg::osg_coord_t         box_max_x,
  output osg_pkg::osg_coord_t         box_min_y,
  output osg_pkg::osg_coord_t         box_max_y,
  output osg_pkg::osg_coord_t         box_min_z,
  output osg_pkg::osg_coord_t         box_max_z,
  output logic                        has_children,
  output logic                        last_node
);
  import osg_pkg::*;

  logic                s1_valid;
  osg_step_t           s1_step;
  logic [NODE_W-1:0]   s1_node;
  logic [PARENT_W-1:0] s1_parent;

  logic      out_free;
  logic      s1_move;
  osg_box_t  src_box;
  osg_box_t  box;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign busy     = s1_valid && !out_free;

  // Children of the root take the root snapshot, others the stored parent box
  always_comb begin
    src_box = (s1_parent == '0) ? root_box : parent_box;
    if (s1_step.is_root) begin
      box = root_box;
    end else begin
      box.z = split(src_box.z, s1_step.slot[2]);
      box.y = split(src_box.y, s1_step.slot[2] ^ s1_step.slot[1]);
      box.x = split(src_box.x, s1_step.slot[1] ^ s1_step.slot[0]);
    end
  end

  assign wr_en   = s1_move;
  assign wr_node = s1_node;
  assign wr_box  = box;

  // Hold the decoded transaction while the parent box is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_step   <= step;
      s1_node   <= node;
      s1_parent <= parent;
    end
  end

  // Output register, advance only when the receiver is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      node_index   <= s1_node;
      parent_index <= s1_step.is_root ? '1 : $signed({1'b0, s1_parent});
      box_min_x    <= box.x.lo;
      box_max_x    <= box.x.hi;
      box_min_y    <= box.y.lo;
      box_max_y    <= box.y.hi;
      box_min_z    <= box.z.lo;
      box_max_z    <= box.z.hi;
      has_children <= s1_step.has_children;
      last_node    <= s1_step.last_node;
    end
  end

endmodule

### src/octree_subdivision_generator.sv
// Complete octree generator, one node per input transaction, breadth-first.
// Input channel: in_valid / in_stall carry restart. restart = 1 begins again
// at the root and emits it; restart = 0 emits the next node. Once the last
// node has gone out, advance transactions are taken but give no result.
// Output channel: out_valid / out_stall carry node_index, parent_index (-1
// for the root), the node box and has_children / last_node flags.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 layer count,
// 1..6 root box min/max for x, y, z); write only while no transaction is open.
// Pipeline: the parent box is read from the store RAM while the decode stage
// holds the transaction, then the midpoint split goes into the output
// register. Throughput is one node per cycle while out_stall is low, set
// by the single read port of the box store, which is read once per
// transaction. When the receiver stalls, the output register holds; once the
// decode stage holds a transaction, in_stall rises until the output moves.
// Reset clears the position to the root and loads the default registers
// (one layer, box 0 to 65536 on each axis); the box store needs no
// clearing pass, as every parent box is written before any child reads it.
module octree_subdivision_generator #(
  parameter int unsigned MAX_LAYERS = osg_pkg::MAX_LAYERS_DEFAULT,
  parameter int unsigned NODE_W     = 3 * MAX_LAYERS + 1,
  parameter int unsigned PARENT_W   = 3 * MAX_LAYERS - 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [NODE_W-1:0]               node_index,
  output logic signed [PARENT_W:0]        parent_index,
  output osg_pkg::osg_coord_t             box_min_x,
  output osg_pkg::osg_coord_t             box_max_x,
  output osg_pkg::osg_coord_t             box_min_y,
  output osg_pkg::osg_coord_t             box_max_y,
  output osg_pkg::osg_coord_t             box_min_z,
  output osg_pkg::osg_coord_t             box_max_z,
  output logic                            has_children,
  output logic                            last_node,
  input  logic                            cfg_we,
  input  logic [osg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [osg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import osg_pkg::*;

  localparam int unsigned STORE_DEPTH = ((1 << (3 * MAX_LAYERS)) - 1) / 7;
  localparam int unsigned AW          = PARENT_W;

  logic [LAYER_W-1:0] layer_count;
  osg_box_t           root_cfg;
  osg_box_t           root_snap;

  osg_step_t           step;
  logic [NODE_W-1:0]   node;
  logic [PARENT_W-1:0] parent;
  logic                accept;
  logic                busy;

  logic                wr_en;
  logic [NODE_W-1:0]   wr_node;
  osg_box_t            wr_box;
  logic                store_we;
  osg_box_t            parent_box;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= LAYER_W'(1);
      root_cfg.x  <= '{hi: COORD_W'(65536), lo: '0};
      root_cfg.y  <= '{hi: COORD_W'(65536), lo: '0};
      root_cfg.z  <= '{hi: COORD_W'(65536), lo: '0};
    end else if (cfg_we) begin
      unique case (osg_reg_t'(cfg_index))
        REG_LAYER_COUNT: layer_count <= cfg_data[LAYER_W-1:0];
        REG_ROOT_MIN_X:  root_cfg.x.lo <= cfg_data;
        REG_ROOT_MAX_X:  root_cfg.x.hi <= cfg_data;
        REG_ROOT_MIN_Y:  root_cfg.y.lo <= cfg_data;
        REG_ROOT_MAX_Y:  root_cfg.y.hi <= cfg_data;
        REG_ROOT_MIN_Z:  root_cfg.z.lo <= cfg_data;
        REG_ROOT_MAX_Z:  root_cfg.z.hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // Snapshot the root box when the root is emitted; its children read it
  always_ff @(posedge clk) begin
    if (accept && step.emit && step.is_root) begin
      root_snap <= root_cfg;
    end
  end

  osg_sequencer #(
    .MAX_LAYERS (MAX_LAYERS),
    .NODE_W     (NODE_W),
    .PARENT_W   (PARENT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .restart     (restart),
    .layer_count (layer_count),
    .step        (step),
    .node        (node),
    .parent      (parent)
  );

  assign store_we = wr_en && (wr_node < NODE_W'(STORE_DEPTH));

  osg_box_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store_x (
    .clk   (clk),
    .we    (store_we),
    .waddr (wr_node[AW-1:0]),
    .wdata (wr_box.x),
    .re    (accept),
    .raddr (parent),
    .rdata (parent_box.x)
  );

  osg_box_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store_y (
    .clk   (clk),
    .we    (store_we),
    .waddr (wr_node[AW-1:0]),
    .wdata (wr_box.y),
    .re    (accept),
    .raddr (parent),
    .rdata (parent_box.y)
  );

  osg_box_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store_z (
    .clk   (clk),
    .we    (store_we),
    .waddr (wr_node[AW-1:0]),
    .wdata (wr_box.z),
    .re    (accept),
    .raddr (parent),
    .rdata (parent_box.z)
  );

  osg_emit_stage #(
    .NODE_W   (NODE_W),
    .PARENT_W (PARENT_W)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && step.emit),
    .step         (step),
    .node         (node),
    .parent       (parent),
    .root_box     (root_snap),
    .parent_box   (parent_box),
    .busy         (busy),
    .wr_en        (wr_en),
    .wr_node      (wr_node),
    .wr_box       (wr_box),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .node_index   (node_index),
    .parent_index (parent_index),
    .box_min_x    (box_min_x),
    .box_max_x    (box_max_x),
    .box_min_y    (box_min_y),
    .box_max_y    (box_max_y),
    .box_min_z    (box_min_z),
    .box_max_z    (box_max_z),
    .has_children (has_children),
    .last_node    (last_node)
  );

endmodule
